[design/dotq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and constants for the deadline ordered timer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

  // Parameter defaults
  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned TickBitsDef = 32;
  localparam int unsigned NumHandles  = 16;

  // Configuration register port
  localparam int unsigned CfgW = 16;
  localparam logic [CfgW-1:0] MinLeadRst     = 16'd1000;
  localparam logic [CfgW-1:0] FireAdvanceRst = 16'd0;
  localparam logic [0:0] CFG_MIN_LEAD     = 1'd0;
  localparam logic [0:0] CFG_FIRE_ADVANCE = 1'd1;

  // Request actions
  localparam logic [1:0] ACT_SCHEDULE   = 2'd0;
  localparam logic [1:0] ACT_UNSCHEDULE = 2'd1;
  localparam logic [1:0] ACT_SERVICE    = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_FIRED   = 2'd1;
  localparam logic [1:0] KIND_COMPARE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  task_handle;
    logic [31:0] deadline;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [3:0]  fired_task;
    logic [31:0] compare_tick;
    logic        last;
  } out_t;

endpackage
`default_nettype wire

[design/dotq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_ram
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module dotq_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 36,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[design/deadline_ordered_timer_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue
// Timer task queue kept sorted by wraparound deadline in a single memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  in_data_i  (dotq_pkg::in_t)
// out       output     out_valid_o / out_stall_i out_data_o (dotq_pkg::out_t)
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One transaction is taken at a time; every queue access goes through the
// single read port of the queue memory, read then check or write per entry.
// Reset clears the entry count and pending flags; the memory is not cleared.
// A stalled result holds in the output register; the sequencer waits at its next result.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue #(
  parameter int unsigned MAX_TASKS = dotq_pkg::MaxTasksDef,
  parameter int unsigned TICK_BITS = dotq_pkg::TickBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire dotq_pkg::in_t         in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output dotq_pkg::out_t             out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_idx_i,
  input  wire logic [dotq_pkg::CfgW-1:0] cfg_wdata_i
);
  import dotq_pkg::*;

  localparam int unsigned QCap  = (MAX_TASKS < NumHandles) ? MAX_TASKS : NumHandles;
  localparam int unsigned AW    = $clog2(QCap);
  localparam int unsigned CW    = $clog2(QCap + 1);
  localparam int unsigned TB    = TICK_BITS;
  localparam int unsigned EW    = 4 + TB;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIND_RD  = 4'd1;
  localparam logic [3:0] S_FIND_CK  = 4'd2;
  localparam logic [3:0] S_DECIDE   = 4'd3;
  localparam logic [3:0] S_RM_RD    = 4'd4;
  localparam logic [3:0] S_RM_WR    = 4'd5;
  localparam logic [3:0] S_SRCH_RD  = 4'd6;
  localparam logic [3:0] S_SRCH_CK  = 4'd7;
  localparam logic [3:0] S_SHU_RD   = 4'd8;
  localparam logic [3:0] S_SHU_WR   = 4'd9;
  localparam logic [3:0] S_INS      = 4'd10;
  localparam logic [3:0] S_STAT     = 4'd11;
  localparam logic [3:0] S_HEAD_RD  = 4'd12;
  localparam logic [3:0] S_HEAD_OUT = 4'd13;
  localparam logic [3:0] S_SVC_RD   = 4'd14;
  localparam logic [3:0] S_SVC_CK   = 4'd15;

  // a is sooner than b under wraparound
  function automatic logic sooner(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB-1:0] diff;
    diff = a - b;
    return diff[TB-1];
  endfunction

  logic [3:0]          state_q, state_d;
  logic [1:0]          act_q, act_d;
  logic [3:0]          hnd_q, hnd_d;
  logic [TB-1:0]       dl_q, dl_d, lim_q, lim_d, due_q, due_d;
  logic [CW-1:0]       idx_q, idx_d, pos_q, pos_d, cnt_q, cnt_d;
  logic                found_q, found_d, lock_q, lock_d, ok_q, ok_d;
  logic [NumHandles-1:0] pend_q, pend_d;
  logic [CfgW-1:0]     min_lead_q, fire_adv_q;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [EW-1:0]       mem_wdata, mem_rdata;
  logic [3:0]          rd_hnd;
  logic [TB-1:0]       rd_dl;
  logic [CW-1:0]       idx_inc;
  logic                can_emit, ok_calc;
  logic [TB+31:0]      in_dl_ext, in_now_ext, rd_dl_ext;
  logic [TB+CfgW-1:0]  lead_ext, adv_ext;

  assign rd_hnd     = mem_rdata[EW-1 -: 4];
  assign rd_dl      = mem_rdata[TB-1:0];
  assign idx_inc    = idx_q + 1'b1;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign in_dl_ext  = {{TB{1'b0}}, in_data_i.deadline};
  assign in_now_ext = {{TB{1'b0}}, in_data_i.now};
  assign rd_dl_ext  = {32'd0, rd_dl};
  assign lead_ext   = {{TB{1'b0}}, min_lead_q};
  assign adv_ext    = {{TB{1'b0}}, fire_adv_q};

  assign ok_calc = !(found_q && lock_q) &&
                   ((act_q == ACT_UNSCHEDULE) ||
                    (!sooner(dl_q, lim_q) && (found_q || (cnt_q < CW'(QCap)))));

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  dotq_ram #(
    .Depth (QCap),
    .Width (EW),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    hnd_d       = hnd_q;
    dl_d        = dl_q;
    lim_d       = lim_q;
    due_d       = due_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    lock_d      = lock_q;
    ok_d        = ok_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = in_data_i.action;
          hnd_d   = in_data_i.task_handle;
          dl_d    = in_dl_ext[TB-1:0];
          lim_d   = in_now_ext[TB-1:0] + lead_ext[TB-1:0];
          due_d   = in_now_ext[TB-1:0] + adv_ext[TB-1:0];
          idx_d   = '0;
          found_d = 1'b0;
          lock_d  = 1'b0;
          case (in_data_i.action)
            ACT_SCHEDULE, ACT_UNSCHEDULE: begin
              state_d = pend_q[in_data_i.task_handle] ? S_FIND_RD : S_DECIDE;
            end
            ACT_SERVICE: begin
              state_d = S_SVC_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Look up the position of a pending handle
      S_FIND_RD: begin
        mem_raddr = idx_q[AW-1:0];
        state_d   = S_FIND_CK;
      end
      S_FIND_CK: begin
        if (rd_hnd == hnd_q) begin
          found_d = 1'b1;
          pos_d   = idx_q;
          lock_d  = sooner(rd_dl, lim_q);
          state_d = S_DECIDE;
        end else if (idx_inc >= cnt_q) begin
          state_d = S_DECIDE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_FIND_RD;
        end
      end

      S_DECIDE: begin
        ok_d = ok_calc;
        if (ok_calc && found_q) begin
          idx_d          = pos_q;
          pend_d[hnd_q]  = 1'b0;
          state_d        = S_RM_RD;
        end else if (ok_calc && (act_q == ACT_SCHEDULE)) begin
          idx_d   = '0;
          state_d = S_SRCH_RD;
        end else begin
          state_d = S_STAT;
        end
      end

      // Close the gap left by a removed entry
      S_RM_RD: begin
        if (idx_inc < cnt_q) begin
          mem_raddr = idx_inc[AW-1:0];
          state_d   = S_RM_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          idx_d = '0;
          case (act_q)
            ACT_SERVICE:  state_d = S_SVC_RD;
            ACT_SCHEDULE: state_d = S_SRCH_RD;
            default:      state_d = S_STAT;
          endcase
        end
      end
      S_RM_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = S_RM_RD;
      end

      // Find the insertion point behind equal deadlines
      S_SRCH_RD: begin
        if (idx_q == cnt_q) begin
          pos_d   = idx_q;
          idx_d   = cnt_q;
          state_d = S_SHU_RD;
        end else begin
          mem_raddr = idx_q[AW-1:0];
          state_d   = S_SRCH_CK;
        end
      end
      S_SRCH_CK: begin
        if (!sooner(dl_q, rd_dl)) begin
          idx_d   = idx_inc;
          state_d = S_SRCH_RD;
        end else begin
          pos_d   = idx_q;
          idx_d   = cnt_q;
          state_d = S_SHU_RD;
        end
      end

      // Open a slot by moving later entries up by one
      S_SHU_RD: begin
        if (idx_q > pos_q) begin
          mem_raddr = AW'(idx_q - 1'b1);
          state_d   = S_SHU_WR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SHU_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = S_SHU_RD;
      end
      S_INS: begin
        mem_we        = 1'b1;
        mem_waddr     = pos_q[AW-1:0];
        mem_wdata     = {hnd_q, dl_q};
        cnt_d         = cnt_q + 1'b1;
        pend_d[hnd_q] = 1'b1;
        state_d       = S_STAT;
      end

      S_STAT: begin
        if (can_emit) begin
          out_valid_d        = 1'b1;
          out_d.kind         = KIND_STATUS;
          out_d.accepted     = ok_q;
          out_d.fired_task   = '0;
          out_d.compare_tick = '0;
          out_d.last         = !(ok_q && (cnt_q != '0));
          state_d            = (ok_q && (cnt_q != '0)) ? S_HEAD_RD : S_IDLE;
        end
      end
      S_HEAD_RD: begin
        state_d = S_HEAD_OUT;
      end
      S_HEAD_OUT: begin
        if (can_emit) begin
          out_valid_d        = 1'b1;
          out_d.kind         = KIND_COMPARE;
          out_d.accepted     = 1'b0;
          out_d.fired_task   = '0;
          out_d.compare_tick = rd_dl_ext[31:0];
          out_d.last         = 1'b1;
          state_d            = S_IDLE;
        end
      end

      // Service event: fire due tasks from the head
      S_SVC_RD: begin
        state_d = (cnt_q == '0) ? S_IDLE : S_SVC_CK;
      end
      S_SVC_CK: begin
        if (can_emit) begin
          out_valid_d      = 1'b1;
          out_d.accepted   = 1'b0;
          if (!sooner(due_q, rd_dl)) begin
            out_d.kind         = KIND_FIRED;
            out_d.fired_task   = rd_hnd;
            out_d.compare_tick = '0;
            out_d.last         = (cnt_q == CW'(1));
            pend_d[rd_hnd]     = 1'b0;
            idx_d              = '0;
            state_d            = S_RM_RD;
          end else begin
            out_d.kind         = KIND_COMPARE;
            out_d.fired_task   = '0;
            out_d.compare_tick = rd_dl_ext[31:0];
            out_d.last         = 1'b1;
            state_d            = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      min_lead_q  <= MinLeadRst;
      fire_adv_q  <= FireAdvanceRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_LEAD:     min_lead_q <= cfg_wdata_i;
          CFG_FIRE_ADVANCE: fire_adv_q <= cfg_wdata_i;
          default:          min_lead_q <= min_lead_q;
        endcase
      end
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    hnd_q   <= hnd_d;
    dl_q    <= dl_d;
    lim_q   <= lim_d;
    due_q   <= due_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    lock_q  <= lock_d;
    ok_q    <= ok_d;
    out_q   <= out_d;
  end

endmodule
`default_nettype wire

[verif/dotq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotq_checker
// Watches the request, result and register ports of the timer queue. It keeps
// its own sorted copy of the queue, works out the results of every accepted
// request and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module dotq_checker
  import dotq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  wire in_t             in_data_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  wire out_t            out_data_i,
  input  wire logic            cfg_we_i,
  input  wire logic [0:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output int                   error_count_o,
  output int                   outstanding_o
);

  // Own copy of the queue and its registers.
  logic [3:0]      q_handle [NumHandles];
  logic [31:0]     q_dl [NumHandles];
  int              q_count;
  logic [CfgW-1:0] lead_window;
  logic [CfgW-1:0] early_fire;

  // Results still to come, oldest first.
  out_t expected_results[$];

  // Wraparound order: a is sooner than b when a - b has its top bit set.
  function automatic logic is_sooner(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic out_t make_result(logic [1:0] kind, logic acc, logic [3:0] task_h,
                                       logic [31:0] cmp);
    out_t r;
    r.kind = kind;
    r.accepted = acc;
    r.fired_task = task_h;
    r.compare_tick = cmp;
    r.last = 1'b0;
    return r;
  endfunction

  // Appends one result behind those already waiting.
  task automatic queue_result(out_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic drop_entry(int pos);
    for (int i = pos; i + 1 < q_count; i++) begin
      q_handle[i] = q_handle[i+1];
      q_dl[i] = q_dl[i+1];
    end
    q_count--;
  endtask

  // Applies one request to the queue copy and appends the results it causes.
  task automatic predict_queue_update(in_t req);
    logic [31:0] window_end;
    logic [31:0] due;
    logic        ok;
    int          pos;
    int          slot;
    int          produced;
    produced = 0;
    if (req.action == ACT_SCHEDULE || req.action == ACT_UNSCHEDULE) begin
      window_end = req.now + 32'(lead_window);
      ok = 1'b1;
      pos = -1;
      for (int i = 0; i < q_count; i++) begin
        if (pos < 0 && q_handle[i] == req.task_handle) pos = i;
      end
      if (pos >= 0 && is_sooner(q_dl[pos], window_end)) ok = 1'b0;
      if (req.action == ACT_SCHEDULE) begin
        if (is_sooner(req.deadline, window_end)) ok = 1'b0;
        if (pos < 0 && q_count >= NumHandles) ok = 1'b0;
      end
      if (ok) begin
        if (pos >= 0) drop_entry(pos);
        if (req.action == ACT_SCHEDULE && q_count < NumHandles) begin
          slot = 0;
          while (slot < q_count && !is_sooner(req.deadline, q_dl[slot])) slot++;
          for (int j = q_count; j > slot; j--) begin
            q_handle[j] = q_handle[j-1];
            q_dl[j] = q_dl[j-1];
          end
          q_handle[slot] = req.task_handle;
          q_dl[slot] = req.deadline;
          q_count++;
        end
      end
      queue_result(make_result(KIND_STATUS, ok, 4'd0, 32'd0));
      produced++;
      if (ok && q_count > 0) begin
        queue_result(make_result(KIND_COMPARE, 1'b0, 4'd0, q_dl[0]));
        produced++;
      end
    end else if (req.action == ACT_SERVICE) begin
      due = req.now + 32'(early_fire);
      while (q_count > 0 && !is_sooner(due, q_dl[0])) begin
        queue_result(make_result(KIND_FIRED, 1'b0, q_handle[0], 32'd0));
        produced++;
        drop_entry(0);
      end
      if (q_count > 0) begin
        queue_result(make_result(KIND_COMPARE, 1'b0, 4'd0, q_dl[0]));
        produced++;
      end
    end
    if (produced > 0) expected_results[$].last = 1'b1;
  endtask

  // Follow every port at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      q_count = 0;
      lead_window = MinLeadRst;
      early_fire = FireAdvanceRst;
      error_count_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MIN_LEAD) lead_window = cfg_wdata_i;
        else if (cfg_idx_i == CFG_FIRE_ADVANCE) early_fire = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) predict_queue_update(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_i);
          error_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.kind !== want.kind || out_data_i.accepted !== want.accepted ||
              out_data_i.fired_task !== want.fired_task ||
              out_data_i.compare_tick !== want.compare_tick ||
              out_data_i.last !== want.last) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data_i);
            error_count_o++;
          end
        end
      end
    end
    outstanding_o = expected_results.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the timer queue with random
// idling on both sides, including one long result hold-off, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
  import dotq_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 100;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b1;
  out_t            out_data;
  logic            cfg_we = 1'b0;
  logic [0:0]      cfg_idx = CFG_MIN_LEAD;
  logic [CfgW-1:0] cfg_wdata = '0;
  int              error_count;
  int              outstanding;
  int              cycle_count = 0;
  logic            quiet = 1'b0;
  logic            long_hold = 1'b0;
  logic [CfgW-1:0] cur_lead = MinLeadRst;
  logic [31:0]     tick_now;

  always #6 clk_i = ~clk_i;

  deadline_ordered_timer_queue i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  dotq_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .error_count_o(error_count), .outstanding_o(outstanding)
  );

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic int idle_cycles();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      k = idle_cycles();
      if (k > 0) begin
        out_stall = 1'b1;
        repeat (k) @(negedge clk_i);
      end
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Offers one transaction and returns at the falling edge after acceptance.
  task automatic send_request(logic [1:0] act, logic [3:0] h, logic [31:0] dl,
                              logic [31:0] now);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data.action = act;
    in_data.task_handle = h;
    in_data.deadline = dl;
    in_data.now = now;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // Waits until every result is in and the block has had time to finish.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CfgW-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CFG_MIN_LEAD) cur_lead = val;
  endtask

  // One stretch of random requests around a moving tick count.
  task automatic random_requests(int count);
    int          r;
    logic [3:0]  h;
    logic [31:0] dl;
    tick_now = $urandom();
    for (int n = 0; n < count; n++) begin
      tick_now = tick_now + $urandom_range(0, 3000);
      r = $urandom_range(0, 99);
      h = 4'($urandom_range(0, 15));
      if (r < 8) dl = $urandom();
      else if (r < 14) dl = tick_now + 32'(cur_lead) - 32'($urandom_range(1, 50));
      else dl = tick_now + 32'(cur_lead) + $urandom_range(0, 20000);
      if (r < 45) send_request(ACT_SCHEDULE, h, dl, tick_now);
      else if (r < 65) send_request(ACT_UNSCHEDULE, h, $urandom(), tick_now);
      else if (r < 97) begin
        send_request(ACT_SERVICE, h, $urandom(), tick_now + $urandom_range(0, 25000));
      end else begin
        send_request(ActUnused, h, $urandom(), $urandom());
        n--;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: too soon, equal deadlines, absent task, locked, move,
    // unused action, compare-only service, fire, empty queue, idle service.
    send_request(ACT_SCHEDULE, 4'd0, 32'd999, 32'd0);
    send_request(ACT_SCHEDULE, 4'd0, 32'd1000, 32'd0);
    send_request(ACT_SCHEDULE, 4'd1, 32'd1000, 32'd0);
    send_request(ACT_UNSCHEDULE, 4'd5, 32'd0, 32'd0);
    send_request(ACT_UNSCHEDULE, 4'd0, 32'd0, 32'd500);
    send_request(ACT_SCHEDULE, 4'd0, 32'd2000, 32'd500);
    send_request(ACT_SCHEDULE, 4'd1, 32'd5000, 32'd0);
    send_request(ActUnused, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_SERVICE, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(ACT_SERVICE, 4'd0, 32'd0, 32'd2000);
    send_request(ACT_UNSCHEDULE, 4'd1, 32'd0, 32'd0);
    send_request(ACT_SERVICE, 4'd0, 32'd0, 32'd0);
    // Full queue, every handle, deadlines across the wrap, then one service.
    for (int i = 0; i < NumHandles; i++) begin
      send_request(ACT_SCHEDULE, 4'(i), 32'hFFFF_FFF0 + 32'(i * 3), 32'hFFFF_0000);
    end
    send_request(ACT_SERVICE, 4'd0, 32'd0, 32'd0);
    wait_idle();

    // Register settings, the extremes among them.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MIN_LEAD, 16'd0);
          write_reg(CFG_FIRE_ADVANCE, 16'd0);
        end
        1: begin
          write_reg(CFG_MIN_LEAD, 16'hFFFF);
          write_reg(CFG_FIRE_ADVANCE, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_MIN_LEAD, 16'd0);
          write_reg(CFG_FIRE_ADVANCE, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_MIN_LEAD, 16'd1000);
          write_reg(CFG_FIRE_ADVANCE, 16'd0);
        end
        default: begin
          write_reg(CFG_MIN_LEAD, 16'($urandom()));
          write_reg(CFG_FIRE_ADVANCE, 16'($urandom()));
        end
      endcase
      quiet = (phase == 3);
      if (phase == 1) long_hold = 1'b1;
      random_requests(70);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
